// File: hdl/c8alu_pkg.sv
// ----------------------------------------------------------------------------
// c8alu_pkg
// shared types and constants of the 8-bit accumulator execute unit:
// operation codes, shift kinds, status bit positions, reset values and stage records
// ----------------------------------------------------------------------------
package c8alu_pkg;

    localparam int unsigned FUNC_W = 6;

    // operation codes
    localparam logic [FUNC_W-1:0] FN_LDA     = 6'd0;
    localparam logic [FUNC_W-1:0] FN_LDX     = 6'd1;
    localparam logic [FUNC_W-1:0] FN_LDY     = 6'd2;
    localparam logic [FUNC_W-1:0] FN_STA     = 6'd3;
    localparam logic [FUNC_W-1:0] FN_STX     = 6'd4;
    localparam logic [FUNC_W-1:0] FN_STY     = 6'd5;
    localparam logic [FUNC_W-1:0] FN_TAX     = 6'd6;
    localparam logic [FUNC_W-1:0] FN_TAY     = 6'd7;
    localparam logic [FUNC_W-1:0] FN_TXA     = 6'd8;
    localparam logic [FUNC_W-1:0] FN_TYA     = 6'd9;
    localparam logic [FUNC_W-1:0] FN_TSX     = 6'd10;
    localparam logic [FUNC_W-1:0] FN_TXS     = 6'd11;
    localparam logic [FUNC_W-1:0] FN_AND     = 6'd12;
    localparam logic [FUNC_W-1:0] FN_EOR     = 6'd13;
    localparam logic [FUNC_W-1:0] FN_ORA     = 6'd14;
    localparam logic [FUNC_W-1:0] FN_BIT     = 6'd15;
    localparam logic [FUNC_W-1:0] FN_ADC     = 6'd16;
    localparam logic [FUNC_W-1:0] FN_SBC     = 6'd17;
    localparam logic [FUNC_W-1:0] FN_CMP     = 6'd18;
    localparam logic [FUNC_W-1:0] FN_CPX     = 6'd19;
    localparam logic [FUNC_W-1:0] FN_CPY     = 6'd20;
    localparam logic [FUNC_W-1:0] FN_INC     = 6'd21;
    localparam logic [FUNC_W-1:0] FN_INX     = 6'd22;
    localparam logic [FUNC_W-1:0] FN_INY     = 6'd23;
    localparam logic [FUNC_W-1:0] FN_DEC     = 6'd24;
    localparam logic [FUNC_W-1:0] FN_DEX     = 6'd25;
    localparam logic [FUNC_W-1:0] FN_DEY     = 6'd26;
    localparam logic [FUNC_W-1:0] FN_ASL_A   = 6'd27;
    localparam logic [FUNC_W-1:0] FN_ASL_M   = 6'd28;
    localparam logic [FUNC_W-1:0] FN_LSR_A   = 6'd29;
    localparam logic [FUNC_W-1:0] FN_LSR_M   = 6'd30;
    localparam logic [FUNC_W-1:0] FN_ROL_A   = 6'd31;
    localparam logic [FUNC_W-1:0] FN_ROL_M   = 6'd32;
    localparam logic [FUNC_W-1:0] FN_ROR_A   = 6'd33;
    localparam logic [FUNC_W-1:0] FN_ROR_M   = 6'd34;
    localparam logic [FUNC_W-1:0] FN_CLC     = 6'd35;
    localparam logic [FUNC_W-1:0] FN_CLD     = 6'd36;
    localparam logic [FUNC_W-1:0] FN_CLI     = 6'd37;
    localparam logic [FUNC_W-1:0] FN_CLV     = 6'd38;
    localparam logic [FUNC_W-1:0] FN_SEC     = 6'd39;
    localparam logic [FUNC_W-1:0] FN_SED     = 6'd40;
    localparam logic [FUNC_W-1:0] FN_SEI     = 6'd41;
    localparam logic [FUNC_W-1:0] FN_NOP     = 6'd42;
    localparam logic [FUNC_W-1:0] FN_PHA     = 6'd43;
    localparam logic [FUNC_W-1:0] FN_PHP     = 6'd44;
    localparam logic [FUNC_W-1:0] FN_PLA     = 6'd45;
    localparam logic [FUNC_W-1:0] FN_PLP     = 6'd46;

    // shift kinds, from (code - ASL_A) >> 1
    localparam logic [1:0] SH_ASL = 2'd0;
    localparam logic [1:0] SH_LSR = 2'd1;
    localparam logic [1:0] SH_ROL = 2'd2;
    localparam logic [1:0] SH_ROR = 2'd3;

    // status bit positions
    localparam int unsigned FL_C = 0;
    localparam int unsigned FL_Z = 1;
    localparam int unsigned FL_I = 2;
    localparam int unsigned FL_D = 3;
    localparam int unsigned FL_B = 4;
    localparam int unsigned FL_U = 5;
    localparam int unsigned FL_V = 6;
    localparam int unsigned FL_N = 7;

    localparam logic [7:0] SP_RESET    = 8'hFD;
    localparam logic [7:0] FLAGS_RESET = 8'h24;

    // architectural registers
    typedef struct packed {
        logic [7:0] acc;
        logic [7:0] x;
        logic [7:0] y;
        logic [7:0] sp;
        logic [7:0] p;
    } arch_t;

    // memory or stack side of one result item
    typedef struct packed {
        logic       mem_write;
        logic [7:0] write_data;
        logic       stack_access;
        logic [7:0] stack_slot;
    } xfer_t;

endpackage

// File: hdl/cpu8_alu_register_execute.sv
// ----------------------------------------------------------------------------
// cpu8_alu_register_execute
// binary-mode execute unit of an 8-bit accumulator processor: holds A, X, Y,
// stack pointer and status byte, runs one operation per item and reports
// the memory or stack write plus all registers afterwards
// ----------------------------------------------------------------------------
//
//  channel | direction | ports                                     | handshake
//  --------+-----------+-------------------------------------------+----------------
//  input   | in        | s_func, s_operand_byte                    | s_valid/s_ready
//  result  | out       | m_mem_write, m_write_data, m_stack_access,| m_valid/m_ready
//          |           | m_stack_slot, m_acc_out, m_x_out,         |
//          |           | m_y_out, m_sp_out, m_flags_out            |
//
//  an accepted item executes from the input register, and the result register
//  loads it as soon as the result slot is free
//  sustained rate is one item per cycle while m_ready is high; each executed item
//  commits to the register file in the same edge, so the next item sees the new values
//  a stall on m_ready holds the result; the input register still takes one
//  more item and s_ready drops only when both registers are full
//  synchronous active-low reset: A, X, Y cleared, sp 0xFD, status 0x24,
//  both stages emptied
//
module cpu8_alu_register_execute (
    input  logic                         aclk,
    input  logic                         aresetn,

    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [c8alu_pkg::FUNC_W-1:0] s_func,
    input  logic [7:0]                   s_operand_byte,

    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_mem_write,
    output logic [7:0]                   m_write_data,
    output logic                         m_stack_access,
    output logic [7:0]                   m_stack_slot,
    output logic [7:0]                   m_acc_out,
    output logic [7:0]                   m_x_out,
    output logic [7:0]                   m_y_out,
    output logic [7:0]                   m_sp_out,
    output logic [7:0]                   m_flags_out
);

    // input register
    logic                         in_valid_reg;
    logic [c8alu_pkg::FUNC_W-1:0] in_func_reg;
    logic [7:0]                   in_operand_reg;

    // architectural register file
    c8alu_pkg::arch_t             arch_reg;
    c8alu_pkg::arch_t             arch_next;

    // result register
    logic                         out_valid_reg;
    c8alu_pkg::arch_t             out_arch_reg;
    c8alu_pkg::xfer_t             out_xfer_reg;
    c8alu_pkg::xfer_t             xfer_next;

    logic                         advance;
    logic                         s_fire;

    // the item in the input register moves on when the result slot is free
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign s_fire  = s_valid && s_ready;

    c8alu_exec u_exec (
        .st           (arch_reg),
        .func         (in_func_reg),
        .operand_byte (in_operand_reg),
        .st_next      (arch_next),
        .xfer         (xfer_next)
    );

    // input stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_fire) begin
            in_func_reg    <= s_func;
            in_operand_reg <= s_operand_byte;
        end
    end

    // register file commits once per executed item, so the next item
    // already sees the new values
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            arch_reg.acc <= 8'd0;
            arch_reg.x   <= 8'd0;
            arch_reg.y   <= 8'd0;
            arch_reg.sp  <= c8alu_pkg::SP_RESET;
            arch_reg.p   <= c8alu_pkg::FLAGS_RESET;
        end else if (advance) begin
            arch_reg <= arch_next;
        end
    end

    // result stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
        if (advance) begin
            out_arch_reg <= arch_next;
            out_xfer_reg <= xfer_next;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_mem_write    = out_xfer_reg.mem_write;
    assign m_write_data   = out_xfer_reg.write_data;
    assign m_stack_access = out_xfer_reg.stack_access;
    assign m_stack_slot   = out_xfer_reg.stack_slot;
    assign m_acc_out      = out_arch_reg.acc;
    assign m_x_out        = out_arch_reg.x;
    assign m_y_out        = out_arch_reg.y;
    assign m_sp_out       = out_arch_reg.sp;
    assign m_flags_out    = out_arch_reg.p;

    // input side only backs up when both stages are full and the sink stalls
    a_ready_only_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready))
        else $error("s_ready low without a stalled result");

    // push leaves sp one below the slot written
    a_push_sp: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_stack_access && m_mem_write) |-> (m_sp_out == m_stack_slot - 8'd1))
        else $error("push result with inconsistent stack pointer");

    // pull leaves sp at the slot read
    a_pull_sp: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_stack_access && !m_mem_write) |-> (m_sp_out == m_stack_slot))
        else $error("pull result with inconsistent stack pointer");

    // no write means no write data, no stack access means no slot
    a_idle_xfer: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_mem_write) |-> (m_write_data == 8'd0))
        else $error("write data present without a write");

    a_idle_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_stack_access) |-> (m_stack_slot == 8'd0))
        else $error("stack slot present without a stack access");

endmodule

// File: hdl/c8alu_exec.sv
// ----------------------------------------------------------------------------
// c8alu_exec
// single-pass execute logic: takes the current registers and one operation,
// gives the updated registers and the memory or stack transfer
// ----------------------------------------------------------------------------
module c8alu_exec (
    input  c8alu_pkg::arch_t                   st,
    input  logic [c8alu_pkg::FUNC_W-1:0]       func,
    input  logic [7:0]                         operand_byte,
    output c8alu_pkg::arch_t                   st_next,
    output c8alu_pkg::xfer_t                   xfer
);

    function automatic logic [7:0] set_nz(input logic [7:0] p, input logic [7:0] v);
        logic [7:0] r;
        r = p;
        r[c8alu_pkg::FL_Z] = (v == 8'd0);
        r[c8alu_pkg::FL_N] = v[7];
        return r;
    endfunction

    logic [7:0]                   addend;
    logic [8:0]                   sum9;
    logic [7:0]                   sum_v;
    logic                         sum_ovf;
    logic [7:0]                   cmp_src;
    logic [8:0]                   diff9;
    logic [c8alu_pkg::FUNC_W-1:0] sh_off;
    logic [1:0]                   sh_kind;
    logic [7:0]                   sh_src;
    logic [7:0]                   sh_res;
    logic                         sh_c;
    logic [7:0]                   inc_v;
    logic [7:0]                   dec_v;

    // shared adder for adc and sbc
    assign addend  = (func == c8alu_pkg::FN_SBC) ? ~operand_byte : operand_byte;
    assign sum9    = {1'b0, st.acc} + {1'b0, addend} + {8'd0, st.p[c8alu_pkg::FL_C]};
    assign sum_v   = sum9[7:0];
    assign sum_ovf = (st.acc[7] ^ sum_v[7]) & (addend[7] ^ sum_v[7]);

    // shared compare subtractor
    always_comb begin
        case (func)
            c8alu_pkg::FN_CPX: cmp_src = st.x;
            c8alu_pkg::FN_CPY: cmp_src = st.y;
            default:           cmp_src = st.acc;
        endcase
    end
    assign diff9 = {1'b0, cmp_src} - {1'b0, operand_byte};

    // shared shifter; odd codes act on A, even codes on memory
    assign sh_off  = func - c8alu_pkg::FN_ASL_A;
    assign sh_kind = sh_off[2:1];
    assign sh_src  = func[0] ? st.acc : operand_byte;
    always_comb begin
        case (sh_kind)
            c8alu_pkg::SH_ASL: begin
                sh_res = {sh_src[6:0], 1'b0};
                sh_c   = sh_src[7];
            end
            c8alu_pkg::SH_LSR: begin
                sh_res = {1'b0, sh_src[7:1]};
                sh_c   = sh_src[0];
            end
            c8alu_pkg::SH_ROL: begin
                sh_res = {sh_src[6:0], st.p[c8alu_pkg::FL_C]};
                sh_c   = sh_src[7];
            end
            default: begin
                sh_res = {st.p[c8alu_pkg::FL_C], sh_src[7:1]};
                sh_c   = sh_src[0];
            end
        endcase
    end

    assign inc_v = operand_byte + 8'd1;
    assign dec_v = operand_byte - 8'd1;

    always_comb begin
        st_next = st;
        xfer    = '0;
        case (func)
            c8alu_pkg::FN_LDA: begin
                st_next.acc = operand_byte;
                st_next.p   = set_nz(st.p, operand_byte);
            end
            c8alu_pkg::FN_LDX: begin
                st_next.x = operand_byte;
                st_next.p = set_nz(st.p, operand_byte);
            end
            c8alu_pkg::FN_LDY: begin
                st_next.y = operand_byte;
                st_next.p = set_nz(st.p, operand_byte);
            end
            c8alu_pkg::FN_STA: begin
                xfer.mem_write  = 1'b1;
                xfer.write_data = st.acc;
            end
            c8alu_pkg::FN_STX: begin
                xfer.mem_write  = 1'b1;
                xfer.write_data = st.x;
            end
            c8alu_pkg::FN_STY: begin
                xfer.mem_write  = 1'b1;
                xfer.write_data = st.y;
            end
            c8alu_pkg::FN_TAX: begin
                st_next.x = st.acc;
                st_next.p = set_nz(st.p, st.acc);
            end
            c8alu_pkg::FN_TAY: begin
                st_next.y = st.acc;
                st_next.p = set_nz(st.p, st.acc);
            end
            c8alu_pkg::FN_TXA: begin
                st_next.acc = st.x;
                st_next.p   = set_nz(st.p, st.x);
            end
            c8alu_pkg::FN_TYA: begin
                st_next.acc = st.y;
                st_next.p   = set_nz(st.p, st.y);
            end
            c8alu_pkg::FN_TSX: begin
                st_next.x = st.sp;
                st_next.p = set_nz(st.p, st.sp);
            end
            c8alu_pkg::FN_TXS: begin
                st_next.sp = st.x;
            end
            c8alu_pkg::FN_AND: begin
                st_next.acc = st.acc & operand_byte;
                st_next.p   = set_nz(st.p, st.acc & operand_byte);
            end
            c8alu_pkg::FN_EOR: begin
                st_next.acc = st.acc ^ operand_byte;
                st_next.p   = set_nz(st.p, st.acc ^ operand_byte);
            end
            c8alu_pkg::FN_ORA: begin
                st_next.acc = st.acc | operand_byte;
                st_next.p   = set_nz(st.p, st.acc | operand_byte);
            end
            c8alu_pkg::FN_BIT: begin
                st_next.p[c8alu_pkg::FL_Z] = ((st.acc & operand_byte) == 8'd0);
                st_next.p[c8alu_pkg::FL_N] = operand_byte[7];
                st_next.p[c8alu_pkg::FL_V] = operand_byte[6];
            end
            c8alu_pkg::FN_ADC, c8alu_pkg::FN_SBC: begin
                st_next.acc                = sum_v;
                st_next.p                  = set_nz(st.p, sum_v);
                st_next.p[c8alu_pkg::FL_C] = sum9[8];
                st_next.p[c8alu_pkg::FL_V] = sum_ovf;
            end
            c8alu_pkg::FN_CMP, c8alu_pkg::FN_CPX, c8alu_pkg::FN_CPY: begin
                st_next.p[c8alu_pkg::FL_C] = ~diff9[8];
                st_next.p[c8alu_pkg::FL_Z] = (diff9[7:0] == 8'd0);
                st_next.p[c8alu_pkg::FL_N] = diff9[7];
            end
            c8alu_pkg::FN_INC: begin
                xfer.mem_write  = 1'b1;
                xfer.write_data = inc_v;
                st_next.p       = set_nz(st.p, inc_v);
            end
            c8alu_pkg::FN_INX: begin
                st_next.x = st.x + 8'd1;
                st_next.p = set_nz(st.p, st.x + 8'd1);
            end
            c8alu_pkg::FN_INY: begin
                st_next.y = st.y + 8'd1;
                st_next.p = set_nz(st.p, st.y + 8'd1);
            end
            c8alu_pkg::FN_DEC: begin
                xfer.mem_write  = 1'b1;
                xfer.write_data = dec_v;
                st_next.p       = set_nz(st.p, dec_v);
            end
            c8alu_pkg::FN_DEX: begin
                st_next.x = st.x - 8'd1;
                st_next.p = set_nz(st.p, st.x - 8'd1);
            end
            c8alu_pkg::FN_DEY: begin
                st_next.y = st.y - 8'd1;
                st_next.p = set_nz(st.p, st.y - 8'd1);
            end
            c8alu_pkg::FN_ASL_A, c8alu_pkg::FN_LSR_A,
            c8alu_pkg::FN_ROL_A, c8alu_pkg::FN_ROR_A: begin
                st_next.acc                = sh_res;
                st_next.p                  = set_nz(st.p, sh_res);
                st_next.p[c8alu_pkg::FL_C] = sh_c;
            end
            c8alu_pkg::FN_ASL_M, c8alu_pkg::FN_LSR_M,
            c8alu_pkg::FN_ROL_M, c8alu_pkg::FN_ROR_M: begin
                xfer.mem_write             = 1'b1;
                xfer.write_data            = sh_res;
                st_next.p                  = set_nz(st.p, sh_res);
                st_next.p[c8alu_pkg::FL_C] = sh_c;
            end
            c8alu_pkg::FN_CLC: st_next.p[c8alu_pkg::FL_C] = 1'b0;
            c8alu_pkg::FN_CLD: st_next.p[c8alu_pkg::FL_D] = 1'b0;
            c8alu_pkg::FN_CLI: st_next.p[c8alu_pkg::FL_I] = 1'b0;
            c8alu_pkg::FN_CLV: st_next.p[c8alu_pkg::FL_V] = 1'b0;
            c8alu_pkg::FN_SEC: st_next.p[c8alu_pkg::FL_C] = 1'b1;
            c8alu_pkg::FN_SED: st_next.p[c8alu_pkg::FL_D] = 1'b1;
            c8alu_pkg::FN_SEI: st_next.p[c8alu_pkg::FL_I] = 1'b1;
            c8alu_pkg::FN_PHA: begin
                xfer.mem_write    = 1'b1;
                xfer.write_data   = st.acc;
                xfer.stack_access = 1'b1;
                xfer.stack_slot   = st.sp;
                st_next.sp        = st.sp - 8'd1;
            end
            c8alu_pkg::FN_PHP: begin
                xfer.mem_write                        = 1'b1;
                xfer.write_data                       = st.p;
                xfer.write_data[c8alu_pkg::FL_B]      = 1'b1;
                xfer.write_data[c8alu_pkg::FL_U]      = 1'b1;
                xfer.stack_access                     = 1'b1;
                xfer.stack_slot                       = st.sp;
                st_next.sp                            = st.sp - 8'd1;
                st_next.p[c8alu_pkg::FL_U]            = 1'b1;
            end
            c8alu_pkg::FN_PLA: begin
                xfer.stack_access = 1'b1;
                xfer.stack_slot   = st.sp + 8'd1;
                st_next.sp        = st.sp + 8'd1;
                st_next.acc       = operand_byte;
                st_next.p         = set_nz(st.p, operand_byte);
            end
            c8alu_pkg::FN_PLP: begin
                xfer.stack_access          = 1'b1;
                xfer.stack_slot            = st.sp + 8'd1;
                st_next.sp                 = st.sp + 8'd1;
                st_next.p                  = operand_byte;
                st_next.p[c8alu_pkg::FL_B] = 1'b0;
                st_next.p[c8alu_pkg::FL_U] = 1'b1;
            end
            default: begin
                // nop and unused codes change nothing
            end
        endcase
    end

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// checks the binary-mode execute unit against a cycle-free register-level
// predictor: a directed table of corner cases, a sweep over every operation
// code, then random instruction streams, with random gaps on both channels
// ----------------------------------------------------------------------------
module testbench;

    localparam int unsigned CLK_HALF     = 5;
    localparam int unsigned RESET_CYCLES = 9;
    localparam int unsigned RANDOM_ITEMS = 840;
    // margin, once no result is owed, for stray results to show up
    localparam int unsigned DRAIN_CYCLES = 8;
    // highest operation code the port can carry; above FN_PLP all act as nop
    localparam logic [c8alu_pkg::FUNC_W-1:0] FN_LAST_CODE = '1;

    // one result item as the block reports it, in port order
    typedef struct packed {
        c8alu_pkg::xfer_t xfer;
        c8alu_pkg::arch_t regs;
    } exec_res_t;

    // directed stimulus row; fixed rows carry a typed-in expectation
    typedef struct packed {
        logic [c8alu_pkg::FUNC_W-1:0] fn;
        logic [7:0]                   opnd;
        logic                         fixed;
        exec_res_t                    res;
    } dir_row_t;

    logic                         aclk = 1'b0;
    logic                         aresetn;
    logic                         s_valid;
    logic                         s_ready;
    logic [c8alu_pkg::FUNC_W-1:0] s_func;
    logic [7:0]                   s_operand_byte;
    logic                         m_valid;
    logic                         m_ready;
    logic                         m_mem_write;
    logic [7:0]                   m_write_data;
    logic                         m_stack_access;
    logic [7:0]                   m_stack_slot;
    logic [7:0]                   m_acc_out;
    logic [7:0]                   m_x_out;
    logic [7:0]                   m_y_out;
    logic [7:0]                   m_sp_out;
    logic [7:0]                   m_flags_out;

    // predicted register file, advanced once per accepted item
    c8alu_pkg::arch_t model_regs;
    // results still owed by the block, oldest first
    exec_res_t        results_due[$];
    dir_row_t         directed_rows[$];
    int               mismatches = 0;
    // when set, neither side inserts idle cycles
    bit               steady = 1'b0;

    cpu8_alu_register_execute dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_func         (s_func),
        .s_operand_byte (s_operand_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_mem_write    (m_mem_write),
        .m_write_data   (m_write_data),
        .m_stack_access (m_stack_access),
        .m_stack_slot   (m_stack_slot),
        .m_acc_out      (m_acc_out),
        .m_x_out        (m_x_out),
        .m_y_out        (m_y_out),
        .m_sp_out       (m_sp_out),
        .m_flags_out    (m_flags_out)
    );

    always #CLK_HALF aclk = ~aclk;

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // update n and z from a result byte and pass the byte through
    function automatic logic [7:0] set_nz(input logic [7:0] v);
        model_regs.p[c8alu_pkg::FL_N] = v[7];
        model_regs.p[c8alu_pkg::FL_Z] = (v == 8'h00);
        return v;
    endfunction

    // run one operation on the predicted registers, return the result item
    function automatic exec_res_t execute_item(input logic [c8alu_pkg::FUNC_W-1:0] fn,
                                               input logic [7:0] opnd);
        exec_res_t                    r;
        logic [8:0]                   sum;
        logic [7:0]                   addend;
        logic [7:0]                   src;
        logic [7:0]                   v;
        logic [c8alu_pkg::FUNC_W-1:0] offs;
        logic [1:0]                   kind;
        logic                         cin;
        r = '0;
        case (fn)
            c8alu_pkg::FN_LDA: model_regs.acc = set_nz(opnd);
            c8alu_pkg::FN_LDX: model_regs.x = set_nz(opnd);
            c8alu_pkg::FN_LDY: model_regs.y = set_nz(opnd);
            c8alu_pkg::FN_STA, c8alu_pkg::FN_STX, c8alu_pkg::FN_STY: begin
                r.xfer.mem_write  = 1'b1;
                r.xfer.write_data = (fn == c8alu_pkg::FN_STA) ? model_regs.acc :
                                    (fn == c8alu_pkg::FN_STX) ? model_regs.x : model_regs.y;
            end
            c8alu_pkg::FN_TAX: model_regs.x = set_nz(model_regs.acc);
            c8alu_pkg::FN_TAY: model_regs.y = set_nz(model_regs.acc);
            c8alu_pkg::FN_TXA: model_regs.acc = set_nz(model_regs.x);
            c8alu_pkg::FN_TYA: model_regs.acc = set_nz(model_regs.y);
            c8alu_pkg::FN_TSX: model_regs.x = set_nz(model_regs.sp);
            // txs leaves the flags alone
            c8alu_pkg::FN_TXS: model_regs.sp = model_regs.x;
            c8alu_pkg::FN_AND: model_regs.acc = set_nz(model_regs.acc & opnd);
            c8alu_pkg::FN_EOR: model_regs.acc = set_nz(model_regs.acc ^ opnd);
            c8alu_pkg::FN_ORA: model_regs.acc = set_nz(model_regs.acc | opnd);
            c8alu_pkg::FN_BIT: begin
                model_regs.p[c8alu_pkg::FL_Z] = ((model_regs.acc & opnd) == 8'h00);
                model_regs.p[c8alu_pkg::FL_N] = opnd[7];
                model_regs.p[c8alu_pkg::FL_V] = opnd[6];
            end
            // sbc is adc of the inverted operand; decimal flag is ignored
            c8alu_pkg::FN_ADC, c8alu_pkg::FN_SBC: begin
                addend = (fn == c8alu_pkg::FN_SBC) ? ~opnd : opnd;
                sum = {1'b0, model_regs.acc} + {1'b0, addend}
                    + {8'd0, model_regs.p[c8alu_pkg::FL_C]};
                v = sum[7:0];
                model_regs.p[c8alu_pkg::FL_C] = sum[8];
                model_regs.p[c8alu_pkg::FL_V] = (model_regs.acc[7] ^ v[7]) & (addend[7] ^ v[7]);
                model_regs.acc = set_nz(v);
            end
            c8alu_pkg::FN_CMP, c8alu_pkg::FN_CPX, c8alu_pkg::FN_CPY: begin
                src = (fn == c8alu_pkg::FN_CMP) ? model_regs.acc :
                      (fn == c8alu_pkg::FN_CPX) ? model_regs.x : model_regs.y;
                v = src - opnd;
                model_regs.p[c8alu_pkg::FL_C] = (src >= opnd);
                model_regs.p[c8alu_pkg::FL_Z] = (src == opnd);
                model_regs.p[c8alu_pkg::FL_N] = v[7];
            end
            c8alu_pkg::FN_INC, c8alu_pkg::FN_DEC: begin
                r.xfer.mem_write  = 1'b1;
                r.xfer.write_data = set_nz((fn == c8alu_pkg::FN_INC) ? opnd + 8'd1
                                                                     : opnd - 8'd1);
            end
            c8alu_pkg::FN_INX: model_regs.x = set_nz(model_regs.x + 8'd1);
            c8alu_pkg::FN_INY: model_regs.y = set_nz(model_regs.y + 8'd1);
            c8alu_pkg::FN_DEX: model_regs.x = set_nz(model_regs.x - 8'd1);
            c8alu_pkg::FN_DEY: model_regs.y = set_nz(model_regs.y - 8'd1);
            // odd codes in this group work on a, even ones on memory
            c8alu_pkg::FN_ASL_A, c8alu_pkg::FN_ASL_M, c8alu_pkg::FN_LSR_A,
            c8alu_pkg::FN_LSR_M, c8alu_pkg::FN_ROL_A, c8alu_pkg::FN_ROL_M,
            c8alu_pkg::FN_ROR_A, c8alu_pkg::FN_ROR_M: begin
                offs = fn - c8alu_pkg::FN_ASL_A;
                kind = offs[2:1];
                src  = fn[0] ? model_regs.acc : opnd;
                cin  = model_regs.p[c8alu_pkg::FL_C];
                if (kind == c8alu_pkg::SH_ASL || kind == c8alu_pkg::SH_ROL) begin
                    model_regs.p[c8alu_pkg::FL_C] = src[7];
                    v = {src[6:0], (kind == c8alu_pkg::SH_ROL) ? cin : 1'b0};
                end else begin
                    model_regs.p[c8alu_pkg::FL_C] = src[0];
                    v = {(kind == c8alu_pkg::SH_ROR) ? cin : 1'b0, src[7:1]};
                end
                v = set_nz(v);
                if (fn[0]) begin
                    model_regs.acc = v;
                end else begin
                    r.xfer.mem_write  = 1'b1;
                    r.xfer.write_data = v;
                end
            end
            c8alu_pkg::FN_CLC: model_regs.p[c8alu_pkg::FL_C] = 1'b0;
            c8alu_pkg::FN_CLD: model_regs.p[c8alu_pkg::FL_D] = 1'b0;
            c8alu_pkg::FN_CLI: model_regs.p[c8alu_pkg::FL_I] = 1'b0;
            c8alu_pkg::FN_CLV: model_regs.p[c8alu_pkg::FL_V] = 1'b0;
            c8alu_pkg::FN_SEC: model_regs.p[c8alu_pkg::FL_C] = 1'b1;
            c8alu_pkg::FN_SED: model_regs.p[c8alu_pkg::FL_D] = 1'b1;
            c8alu_pkg::FN_SEI: model_regs.p[c8alu_pkg::FL_I] = 1'b1;
            // push writes at sp, then sp moves down; php pushes b and bit 5 set
            c8alu_pkg::FN_PHA, c8alu_pkg::FN_PHP: begin
                if (fn == c8alu_pkg::FN_PHP) model_regs.p[c8alu_pkg::FL_U] = 1'b1;
                r.xfer.mem_write    = 1'b1;
                r.xfer.stack_access = 1'b1;
                r.xfer.stack_slot   = model_regs.sp;
                if (fn == c8alu_pkg::FN_PHA) begin
                    r.xfer.write_data = model_regs.acc;
                end else begin
                    r.xfer.write_data                  = model_regs.p;
                    r.xfer.write_data[c8alu_pkg::FL_B] = 1'b1;
                    r.xfer.write_data[c8alu_pkg::FL_U] = 1'b1;
                end
                model_regs.sp = model_regs.sp - 8'd1;
            end
            // pull moves sp up first and reads there
            c8alu_pkg::FN_PLA, c8alu_pkg::FN_PLP: begin
                model_regs.sp       = model_regs.sp + 8'd1;
                r.xfer.stack_access = 1'b1;
                r.xfer.stack_slot   = model_regs.sp;
                if (fn == c8alu_pkg::FN_PLA) begin
                    model_regs.acc = set_nz(opnd);
                end else begin
                    model_regs.p                  = opnd;
                    model_regs.p[c8alu_pkg::FL_B] = 1'b0;
                    model_regs.p[c8alu_pkg::FL_U] = 1'b1;
                end
            end
            default: ;
        endcase
        r.regs = model_regs;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    function automatic dir_row_t plain_row(input logic [c8alu_pkg::FUNC_W-1:0] fn,
                                           input logic [7:0] opnd);
        dir_row_t row;
        row = '0;
        row.fn = fn;
        row.opnd = opnd;
        return row;
    endfunction

    function automatic dir_row_t fixed_row(input logic [c8alu_pkg::FUNC_W-1:0] fn,
                                           input logic [7:0] opnd,
                                           input logic wr, input logic [7:0] wd,
                                           input logic sa, input logic [7:0] slot,
                                           input logic [7:0] a, input logic [7:0] x,
                                           input logic [7:0] y, input logic [7:0] sp,
                                           input logic [7:0] p);
        dir_row_t row;
        row.fn = fn;
        row.opnd = opnd;
        row.fixed = 1'b1;
        row.res = {wr, wd, sa, slot, a, x, y, sp, p};
        return row;
    endfunction

    // idle cycles before the next item, or stall before the next result
    function automatic int unsigned draw_wait();
        return steady ? 0 : $urandom_range(0, 4);
    endfunction

    // operand with the byte extremes and sign boundaries weighted up
    function automatic logic [7:0] draw_operand();
        case ($urandom_range(0, 11))
            0: return 8'h00;
            1: return 8'hFF;
            2: return 8'h80;
            3: return 8'h7F;
            4: return 8'h01;
            5: return 8'h40;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // present one item, hold it until accepted, then log what it must produce
    task automatic send_item(input logic [c8alu_pkg::FUNC_W-1:0] fn,
                             input logic [7:0] opnd,
                             input logic use_fixed, input exec_res_t fixed_res);
        int unsigned gap;
        exec_res_t   predicted;
        gap = draw_wait();
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_func         <= fn;
        s_operand_byte <= opnd;
        do @(posedge aclk); while (!s_ready);
        // predictor always runs so its registers keep step with the block
        predicted = execute_item(fn, opnd);
        results_due.push_back(use_fixed ? fixed_res : predicted);
    endtask

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %02h, got %02h", name, want, got);
            mismatches++;
        end
    endtask

    // ------------------------------------------------------------------
    // input side: directed table, code sweep, random stream
    // ------------------------------------------------------------------
    initial begin
        logic [c8alu_pkg::FUNC_W-1:0] fn;
        int unsigned                  pick;
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_func         = c8alu_pkg::FN_NOP;
        s_operand_byte = 8'h00;
        model_regs     = '{acc: 8'h00, x: 8'h00, y: 8'h00, sp: c8alu_pkg::SP_RESET,
                           p: c8alu_pkg::FLAGS_RESET};

        // state right after reset, then php of the reset flags
        directed_rows.push_back(fixed_row(c8alu_pkg::FN_NOP, 8'h00,
            1'b0, 8'h00, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFD, 8'h24));
        directed_rows.push_back(fixed_row(c8alu_pkg::FN_PHP, 8'h00,
            1'b1, 8'h34, 1'b1, 8'hFD, 8'h00, 8'h00, 8'h00, 8'hFC, 8'h24));
        // plp of all ones: b comes back clear
        directed_rows.push_back(fixed_row(c8alu_pkg::FN_PLP, 8'hFF,
            1'b0, 8'h00, 1'b1, 8'hFD, 8'h00, 8'h00, 8'h00, 8'hFD, 8'hEF));
        directed_rows.push_back(fixed_row(c8alu_pkg::FN_LDA, 8'h80,
            1'b0, 8'h00, 1'b0, 8'h00, 8'h80, 8'h00, 8'h00, 8'hFD, 8'hED));
        directed_rows.push_back(fixed_row(c8alu_pkg::FN_LDA, 8'h00,
            1'b0, 8'h00, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFD, 8'h6F));
        // plp of zero: bit 5 forced back on
        directed_rows.push_back(fixed_row(c8alu_pkg::FN_PLP, 8'h00,
            1'b0, 8'h00, 1'b1, 8'hFE, 8'h00, 8'h00, 8'h00, 8'hFE, 8'h20));
        // signed overflow on adc, borrow and overflow on sbc
        directed_rows.push_back(plain_row(c8alu_pkg::FN_LDA, 8'h7F));
        directed_rows.push_back(plain_row(c8alu_pkg::FN_ADC, 8'h01));
        directed_rows.push_back(plain_row(c8alu_pkg::FN_SBC, 8'h00));
        // decimal flag set, adc must stay binary
        directed_rows.push_back(plain_row(c8alu_pkg::FN_SED, 8'h00));
        directed_rows.push_back(plain_row(c8alu_pkg::FN_ADC, 8'h99));
        directed_rows.push_back(plain_row(c8alu_pkg::FN_SEC, 8'h00));
        directed_rows.push_back(plain_row(c8alu_pkg::FN_SBC, 8'h80));
        directed_rows.push_back(plain_row(c8alu_pkg::FN_CLD, 8'h00));
        directed_rows.push_back(plain_row(c8alu_pkg::FN_CMP, 8'hFF));
        // read-modify-write wrapping both ways
        directed_rows.push_back(plain_row(c8alu_pkg::FN_INC, 8'hFF));
        directed_rows.push_back(plain_row(c8alu_pkg::FN_DEC, 8'h00));
        // stack pointer at zero: push wraps down, pull wraps back up
        directed_rows.push_back(plain_row(c8alu_pkg::FN_LDX, 8'h00));
        directed_rows.push_back(plain_row(c8alu_pkg::FN_TXS, 8'h00));
        directed_rows.push_back(plain_row(c8alu_pkg::FN_PHA, 8'h00));
        directed_rows.push_back(plain_row(c8alu_pkg::FN_PLA, 8'h80));
        directed_rows.push_back(plain_row(c8alu_pkg::FN_DEX, 8'h00));
        // carry into and out of rotates
        directed_rows.push_back(plain_row(c8alu_pkg::FN_ROR_M, 8'h01));
        directed_rows.push_back(plain_row(c8alu_pkg::FN_ROL_A, 8'h00));
        directed_rows.push_back(plain_row(c8alu_pkg::FN_BIT, 8'hC0));
        // unused code behaves as nop
        directed_rows.push_back(plain_row(FN_LAST_CODE, 8'h55));

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i])
            send_item(directed_rows[i].fn, directed_rows[i].opnd,
                      directed_rows[i].fixed, directed_rows[i].res);

        // every code once, unused ones included
        for (int unsigned code = 0; code <= FN_LAST_CODE; code++)
            send_item(code[c8alu_pkg::FUNC_W-1:0], draw_operand(), 1'b0, '0);

        // random stream; mostly defined operations, an occasional unused code,
        // and stretches where neither side idles
        for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 100 == 0) steady = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 19) == 0)
                pick = $urandom_range(c8alu_pkg::FN_PLP + 1, FN_LAST_CODE);
            else
                pick = $urandom_range(0, c8alu_pkg::FN_PLP);
            fn = pick[c8alu_pkg::FUNC_W-1:0];
            send_item(fn, draw_operand(), 1'b0, '0);
        end
        s_valid <= 1'b0;

        // drain, then give a late extra result time to show up
        while (results_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0)
            $display("cpu8_alu_register_execute verification clean");
        else
            $display("cpu8_alu_register_execute verification failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // result side: random stall per item, then take it
    // ------------------------------------------------------------------
    initial begin
        int unsigned stall;
        m_ready = 1'b0;
        wait (aresetn);
        forever begin
            stall = draw_wait();
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    // compare every accepted result with the oldest owed one
    always @(posedge aclk) begin
        exec_res_t want;
        exec_res_t got;
        if (aresetn && m_valid && m_ready) begin
            got = {m_mem_write, m_write_data, m_stack_access, m_stack_slot,
                   m_acc_out, m_x_out, m_y_out, m_sp_out, m_flags_out};
            if (results_due.size() == 0) begin
                $error("result item with nothing expected");
                mismatches++;
            end else begin
                want = results_due.pop_front();
                check_field("mem_write", {7'd0, want.xfer.mem_write},
                            {7'd0, got.xfer.mem_write});
                check_field("write_data", want.xfer.write_data, got.xfer.write_data);
                check_field("stack_access", {7'd0, want.xfer.stack_access},
                            {7'd0, got.xfer.stack_access});
                check_field("stack_slot", want.xfer.stack_slot, got.xfer.stack_slot);
                check_field("acc_out", want.regs.acc, got.regs.acc);
                check_field("x_out", want.regs.x, got.regs.x);
                check_field("y_out", want.regs.y, got.regs.y);
                check_field("sp_out", want.regs.sp, got.regs.sp);
                check_field("flags_out", want.regs.p, got.regs.p);
            end
        end
    end

    // hard stop, far beyond what a correct run needs
    initial begin
        #2_000_000;
        $display("cpu8_alu_register_execute verification failed");
        $finish;
    end

endmodule
